// File: rtl/bdc_pkg.sv
// Shared types and constants for the de Casteljau Bezier evaluator.
// Used by bdc_ctrl, bdc_datapath and the top level; no dependencies.
package bdc_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 16;
	localparam int T_W        = 17;
	localparam int PROD_W     = 35;

	localparam logic [T_W-1:0] ONE_Q16 = T_W'(65536);

	localparam logic [2:0] ACT_APPEND  = 3'd0;
	localparam logic [2:0] ACT_CLEAR   = 3'd1;
	localparam logic [2:0] ACT_DROP    = 3'd2;
	localparam logic [2:0] ACT_EVAL    = 3'd3;
	localparam logic [2:0] ACT_SUBDIV  = 3'd4;

	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_EMPTY   = 2'd1;
	localparam logic [1:0] ERR_FULL    = 2'd2;

	typedef struct packed {
		logic        [2:0]         action;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic        [T_W-1:0]     eval_t;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic                      right_half;
		logic                      last;
		logic        [1:0]         error;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic             load_in;
		logic             cp_we;
		logic             copy_rd;
		logic             lvl_rd;
		logic             emit_rd;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] level;
		logic             out_load;
		logic             out_right;
		logic             out_last;
		logic [1:0]       out_err;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} dp_status_t;

endpackage

// File: rtl/bdc_datapath.sv
// Datapath: control point store, work and left-polygon memories, one
// interpolation lane per coordinate, and the result register. Uses bdc_pkg.
module bdc_datapath import bdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  point_t     in_point,
	input  logic [T_W-1:0] t_in,
	output dp_status_t status,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data
);

	point_t cp_mem [MAX_POINTS];
	point_t wk_mem [MAX_POINTS];
	point_t lf_mem [MAX_POINTS];

	point_t         pt_q;
	logic [T_W-1:0] t_q;
	point_t         cp_rdata_q;
	point_t         wk_rdata_q;
	point_t         lf_rdata_q;
	point_t         prev_q;

	logic             copy_s1;
	logic             lvl_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] level_s1;

	logic                     wv_s2;
	logic [IDX_W-1:0]         widx_s2;
	logic [IDX_W-1:0]         level_s2;
	logic signed [PROD_W-1:0] prod_x_s2;
	logic signed [PROD_W-1:0] prod_y_s2;
	logic signed [COORD_W-1:0] a_x_s2;
	logic signed [COORD_W-1:0] a_y_s2;

	logic             out_valid_q;
	out_item_t        out_q;

	logic signed [COORD_W:0]  dx;
	logic signed [COORD_W:0]  dy;
	logic signed [T_W:0]      t_s;
	logic signed [PROD_W-1:0] prod_x;
	logic signed [PROD_W-1:0] prod_y;
	logic signed [PROD_W-1:0] rnd_x;
	logic signed [PROD_W-1:0] rnd_y;
	point_t                   lerp_res;
	point_t                   out_pt;

	// b - a, times t; a + round(product / 2^16), halves toward +inf
	assign dx     = {wk_rdata_q.x[COORD_W-1], wk_rdata_q.x} - {prev_q.x[COORD_W-1], prev_q.x};
	assign dy     = {wk_rdata_q.y[COORD_W-1], wk_rdata_q.y} - {prev_q.y[COORD_W-1], prev_q.y};
	assign t_s    = $signed({1'b0, t_q});
	assign prod_x = PROD_W'(dx * t_s);
	assign prod_y = PROD_W'(dy * t_s);
	assign rnd_x  = prod_x_s2 + PROD_W'(32768);
	assign rnd_y  = prod_y_s2 + PROD_W'(32768);
	assign lerp_res.x = a_x_s2 + rnd_x[31:16];
	assign lerp_res.y = a_y_s2 + rnd_y[31:16];

	assign out_pt = cmd.out_right ? wk_rdata_q : lf_rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pt_q <= in_point;
			t_q  <= t_in;
		end
		if (cmd.cp_we) begin
			cp_mem[cmd.idx] <= pt_q;
		end
		if (cmd.copy_rd) begin
			cp_rdata_q <= cp_mem[cmd.idx];
		end
		if (cmd.lvl_rd || cmd.emit_rd) begin
			wk_rdata_q <= wk_mem[cmd.idx];
		end
		if (cmd.emit_rd) begin
			lf_rdata_q <= lf_mem[cmd.idx];
		end
		if (copy_s1) begin
			wk_mem[idx_s1] <= cp_rdata_q;
		end else if (wv_s2) begin
			wk_mem[widx_s2] <= lerp_res;
		end
		if (copy_s1 && idx_s1 == '0) begin
			lf_mem[0] <= cp_rdata_q;
		end else if (wv_s2 && widx_s2 == '0) begin
			lf_mem[level_s2] <= lerp_res;
		end
		idx_s1   <= cmd.idx;
		level_s1 <= cmd.level;
		if (lvl_s1) begin
			prev_q    <= wk_rdata_q;
			prod_x_s2 <= prod_x;
			prod_y_s2 <= prod_y;
			a_x_s2    <= prev_q.x;
			a_y_s2    <= prev_q.y;
			widx_s2   <= idx_s1 - IDX_W'(1);
			level_s2  <= level_s1;
		end
		if (cmd.out_load) begin
			out_q.out_x      <= (cmd.out_err != ERR_OK) ? '0 : out_pt.x;
			out_q.out_y      <= (cmd.out_err != ERR_OK) ? '0 : out_pt.y;
			out_q.right_half <= cmd.out_right;
			out_q.last       <= cmd.out_last;
			out_q.error      <= cmd.out_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_s1     <= 1'b0;
			lvl_s1      <= 1'b0;
			wv_s2       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			copy_s1 <= cmd.copy_rd;
			lvl_s1  <= cmd.lvl_rd;
			wv_s2   <= lvl_s1 && (idx_s1 != '0);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.busy     = copy_s1 | lvl_s1 | wv_s2;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

// File: rtl/bdc_ctrl.sv
// Controller: decodes actions, keeps the point count and sequences copy,
// interpolation levels and result beats. Uses bdc_pkg.
module bdc_ctrl import bdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] in_action,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DECODE  = 3'd1;
	localparam logic [2:0] ST_ERR     = 3'd2;
	localparam logic [2:0] ST_COPY    = 3'd3;
	localparam logic [2:0] ST_DRAIN   = 3'd4;
	localparam logic [2:0] ST_LVL     = 3'd5;
	localparam logic [2:0] ST_EMIT_RD = 3'd6;
	localparam logic [2:0] ST_EMIT_LD = 3'd7;

	logic [2:0]       state_q;
	logic [2:0]       action_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] level_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0]       err_q;
	logic             half_q;

	logic [CNT_W-1:0] idx_w;
	logic [CNT_W-1:0] last_idx;
	logic [CNT_W-1:0] lvl_end;
	logic             is_eval;
	logic             emit_last;

	assign idx_w     = CNT_W'(idx_q);
	assign last_idx  = count_q - CNT_W'(1);
	assign lvl_end   = count_q - level_q;
	assign is_eval   = (action_q == ACT_EVAL);
	assign emit_last = is_eval || (half_q && idx_w == last_idx);
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load_in   = in_valid && in_ready;
		cmd.idx       = idx_q;
		cmd.level     = level_q[IDX_W-1:0];
		cmd.out_right = half_q;
		cmd.out_last  = 1'b1;
		cmd.out_err   = err_q;
		unique case (state_q)
			ST_DECODE: begin
				cmd.idx   = count_q[IDX_W-1:0];
				cmd.cp_we = (action_q == ACT_APPEND) && (count_q != CNT_W'(MAX_POINTS));
			end
			ST_ERR: begin
				cmd.out_load  = status.out_free;
				cmd.out_right = 1'b0;
			end
			ST_COPY: begin
				cmd.copy_rd = 1'b1;
			end
			ST_LVL: begin
				cmd.lvl_rd = 1'b1;
			end
			ST_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
			end
			ST_EMIT_LD: begin
				cmd.out_load = status.out_free;
				cmd.out_last = emit_last;
				cmd.out_err  = ERR_OK;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			action_q <= ACT_APPEND;
			count_q  <= '0;
			level_q  <= '0;
			idx_q    <= '0;
			err_q    <= ERR_OK;
			half_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						action_q <= in_action;
						state_q  <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					idx_q   <= '0;
					half_q  <= 1'b0;
					state_q <= ST_IDLE;
					case (action_q)
						ACT_APPEND: begin
							if (count_q == CNT_W'(MAX_POINTS)) begin
								err_q   <= ERR_FULL;
								state_q <= ST_ERR;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						ACT_CLEAR: begin
							count_q <= '0;
						end
						ACT_DROP: begin
							if (count_q == '0) begin
								err_q   <= ERR_EMPTY;
								state_q <= ST_ERR;
							end else begin
								count_q <= last_idx;
							end
						end
						ACT_EVAL, ACT_SUBDIV: begin
							if (count_q == '0) begin
								err_q   <= ERR_EMPTY;
								state_q <= ST_ERR;
							end else begin
								state_q <= ST_COPY;
							end
						end
						default: begin
						end
					endcase
				end
				ST_ERR: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COPY: begin
					if (idx_w == last_idx) begin
						idx_q   <= '0;
						level_q <= CNT_W'(1);
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!status.busy) begin
						if (level_q == count_q) begin
							idx_q   <= is_eval ? last_idx[IDX_W-1:0] : '0;
							half_q  <= 1'b0;
							state_q <= ST_EMIT_RD;
						end else begin
							idx_q   <= '0;
							state_q <= ST_LVL;
						end
					end
				end
				ST_LVL: begin
					if (idx_w == lvl_end) begin
						idx_q   <= '0;
						level_q <= level_q + CNT_W'(1);
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (status.out_free) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else if (idx_w == last_idx) begin
							half_q  <= 1'b1;
							idx_q   <= '0;
							state_q <= ST_EMIT_RD;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/bezier_de_casteljau_evaluator_unit.sv
// Top level of the de Casteljau Bezier evaluator: split point register,
// parameter saturation, controller and datapath. Uses bdc_pkg, bdc_ctrl, bdc_datapath.
//
// Stores up to MAX_POINTS control points (Q12.4) and takes one action per input
// beat: append, clear, drop last, evaluate at eval_t, or subdivide at split_point
// (both Q1.16, values above 1.0 saturate). Items are handled one at a time.
// Append, clear and drop pass through a decode state before the next accept. With n
// points, evaluate runs a copy pass over the n points and a drain, then per level
// one work-memory read per point of the previous level plus a drain of the
// interpolation pipe, then a read and a load for the result beat. Subdivide
// spends a read and a load on each of its 2n beats, left polygon first, then
// right polygon with last on the final beat. Waiting on out_ready in the output
// register stalls these steps. The single read port of the work memory sets the
// pace. Empty or full store gives one error beat. split_point resets to one half.
module bezier_de_casteljau_evaluator_unit import bdc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  in_item_t       in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output out_item_t      out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [T_W-1:0] cfg_data
);

	logic [T_W-1:0] split_q;
	logic [T_W-1:0] t_raw;
	logic [T_W-1:0] t_sat;
	dp_cmd_t        cmd;
	dp_status_t     status;
	point_t         in_point;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= T_W'(32768);
		end else if (cfg_valid) begin
			split_q <= cfg_data;
		end
	end

	assign t_raw      = (in_data.action == ACT_SUBDIV) ? split_q : in_data.eval_t;
	assign t_sat      = (t_raw > ONE_Q16) ? ONE_Q16 : t_raw;
	assign in_point.x = in_data.point_x;
	assign in_point.y = in_data.point_y;

	bdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_action (in_data.action),
		.status    (status),
		.cmd       (cmd)
	);

	bdc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_point  (in_point),
		.t_in      (t_sat),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: tb/bezier_de_casteljau_evaluator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bezier_de_casteljau_evaluator_unit: a directed table, then
// random curve sequences under several split settings, checked by an in-bench predictor.
// Depends on bdc_pkg and the RTL only.
module bezier_de_casteljau_evaluator_unit_tb;
	import bdc_pkg::*;

	localparam logic [2:0]               ACT_RSVD_LO     = 3'd5;
	localparam logic [2:0]               ACT_RSVD_HI     = 3'd7;
	localparam logic [T_W-1:0]           T_MAX           = '1;
	localparam logic [T_W-1:0]           SPLIT_RESET     = T_W'(32768);
	localparam logic signed [COORD_W-1:0] C_MIN          = 16'sh8000;
	localparam logic signed [COORD_W-1:0] C_MAX          = 16'sh7fff;
	localparam int                       WATCHDOG_LIMIT  = 4000;
	localparam int                       LONG_HOLD       = 400;
	localparam int                       SETTLE          = 16;
	localparam int                       PHASES          = 7;
	localparam int                       ITEMS_PER_PHASE = 40;
	localparam int                       DIR_ROWS        = 22;

	localparam out_item_t NO_BEAT     = '0;
	localparam out_item_t EMPTY_BEAT  = '{out_x: '0, out_y: '0, right_half: 1'b0, last: 1'b1,
		error: ERR_EMPTY};
	localparam out_item_t FULL_BEAT   = '{out_x: '0, out_y: '0, right_half: 1'b0, last: 1'b1,
		error: ERR_FULL};
	localparam out_item_t CORNER_BEAT = '{out_x: C_MIN, out_y: C_MAX, right_half: 1'b0,
		last: 1'b1, error: ERR_OK};
	localparam out_item_t OPP_BEAT    = '{out_x: C_MAX, out_y: C_MIN, right_half: 1'b0,
		last: 1'b1, error: ERR_OK};

	typedef struct packed {
		in_item_t   item;
		logic [4:0] reps;
		logic       has_beat;
		out_item_t  beat;
	} dir_row_t;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           in_valid;
	logic           in_ready;
	in_item_t       in_data;
	logic           out_valid;
	logic           out_ready;
	out_item_t      out_data;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [T_W-1:0] cfg_data;

	point_t         cp_store [MAX_POINTS];
	int             cp_count = 0;
	logic [T_W-1:0] split_q16 = SPLIT_RESET;
	out_item_t      expected_beats [$];
	out_item_t      want;
	int             mismatches = 0;
	int             idle_cycles = 0;
	int             items_sent = 0;
	bit             calm_phase = 1'b0;
	bit             calm_seq = 1'b0;
	bit             long_hold_req = 1'b0;
	dir_row_t       dir_table [DIR_ROWS];

	always #6 clk = ~clk;

	bezier_de_casteljau_evaluator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	function automatic logic [T_W-1:0] clamp_t(input logic [T_W-1:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	function automatic void add_beat(ref out_item_t q [$], input out_item_t b);
		q.insert(q.size(), b);
	endfunction

	// (a*(1-t) + b*t + 0.5) floored, t in Q1.16
	function automatic logic signed [COORD_W-1:0] interp_coord(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b,
		input logic [T_W-1:0]            t
	);
		longint acc;
		acc = longint'(a) * longint'(ONE_Q16 - t) + longint'(b) * longint'(t) + 64'sd32768;
		return COORD_W'(acc >>> 16);
	endfunction

	function automatic point_t interp_point(input point_t p, input point_t q,
		input logic [T_W-1:0] t);
		return '{y: interp_coord(p.y, q.y, t), x: interp_coord(p.x, q.x, t)};
	endfunction

	function automatic void casteljau_predict(input in_item_t it, ref out_item_t beats [$]);
		point_t         wk [MAX_POINTS];
		point_t         right_poly [MAX_POINTS];
		logic [T_W-1:0] t;
		int             n;
		n = cp_count;
		case (it.action)
		ACT_APPEND: begin
			if (n >= MAX_POINTS) begin
				add_beat(beats, FULL_BEAT);
			end else begin
				cp_store[n] = '{y: it.point_y, x: it.point_x};
				cp_count = n + 1;
			end
		end
		ACT_CLEAR: begin
			cp_count = 0;
		end
		ACT_DROP: begin
			if (n == 0)
				add_beat(beats, EMPTY_BEAT);
			else
				cp_count = n - 1;
		end
		ACT_EVAL: begin
			if (n == 0) begin
				add_beat(beats, EMPTY_BEAT);
			end else begin
				t = clamp_t(it.eval_t);
				wk = cp_store;
				for (int j = 1; j < n; j++)
					for (int i = 0; i + j < n; i++)
						wk[i] = interp_point(wk[i], wk[i + 1], t);
				add_beat(beats, '{wk[0].x, wk[0].y, 1'b0, 1'b1, ERR_OK});
			end
		end
		ACT_SUBDIV: begin
			if (n == 0) begin
				add_beat(beats, EMPTY_BEAT);
			end else begin
				t = clamp_t(split_q16);
				wk = cp_store;
				right_poly[n - 1] = wk[n - 1];
				add_beat(beats, '{wk[0].x, wk[0].y, 1'b0, 1'b0, ERR_OK});
				for (int j = 1; j < n; j++) begin
					for (int i = 0; i + j < n; i++)
						wk[i] = interp_point(wk[i], wk[i + 1], t);
					add_beat(beats, '{wk[0].x, wk[0].y, 1'b0, 1'b0, ERR_OK});
					right_poly[n - 1 - j] = wk[n - 1 - j];
				end
				for (int i = 0; i < n; i++)
					add_beat(beats, '{right_poly[i].x, right_poly[i].y, 1'b1, (i == n - 1),
						ERR_OK});
			end
		end
		default: ;
		endcase
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
		0: return C_MIN;
		1: return C_MAX;
		default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic logic [T_W-1:0] rand_t();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return ONE_Q16;
		2: return T_W'($urandom_range(ONE_Q16 + 1, T_MAX));
		default: return T_W'($urandom_range(0, ONE_Q16));
		endcase
	endfunction

	task automatic send_item(input in_item_t it, input bit has_beat, input out_item_t beat);
		int        gap;
		out_item_t beats [$];
		gap = (calm_phase || calm_seq) ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		casteljau_predict(it, beats);
		if (has_beat) begin
			beats.delete();
			add_beat(beats, beat);
		end
		foreach (beats[k])
			add_beat(expected_beats, beats[k]);
		if (it.action <= ACT_SUBDIV)
			items_sent++;
	endtask

	task automatic drain(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_split(input logic [T_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		split_q16 = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// clear, build a curve, then query or edit it; a few runs overflow the store
	task automatic run_curve_sequence();
		in_item_t it;
		int       npts;
		int       pick;
		calm_seq = ($urandom_range(0, 7) == 0);
		it = '0;
		it.action = ACT_CLEAR;
		it.eval_t = rand_t();
		send_item(it, 1'b0, NO_BEAT);
		pick = $urandom_range(0, 9);
		if (pick < 6)
			npts = $urandom_range(1, 5);
		else if (pick < 9)
			npts = $urandom_range(6, MAX_POINTS);
		else
			npts = $urandom_range(MAX_POINTS + 1, MAX_POINTS + 3);
		repeat (npts) begin
			it.action  = ACT_APPEND;
			it.point_x = rand_coord();
			it.point_y = rand_coord();
			it.eval_t  = rand_t();
			send_item(it, 1'b0, NO_BEAT);
		end
		repeat ($urandom_range(1, 4)) begin
			it.point_x = rand_coord();
			it.point_y = rand_coord();
			it.eval_t  = rand_t();
			case ($urandom_range(0, 5))
			0: it.action = ACT_SUBDIV;
			1: it.action = ACT_DROP;
			2: it.action = ACT_APPEND;
			default: it.action = ACT_EVAL;
			endcase
			send_item(it, 1'b0, NO_BEAT);
		end
		calm_seq = 1'b0;
	endtask

	initial begin
		logic [T_W-1:0] split_plan [PHASES];
		in_item_t       it;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		split_plan = '{'0, ONE_Q16, T_MAX, T_W'(1), T_W'(65535),
			T_W'($urandom_range(1, 65535)), T_W'($urandom_range(0, T_MAX))};
		dir_table = '{
			'{'{ACT_DROP,    16'sd0,    16'sd0,    17'd0},     5'd1,  1'b1, EMPTY_BEAT},
			'{'{ACT_EVAL,    16'sd0,    16'sd0,    17'd0},     5'd1,  1'b1, EMPTY_BEAT},
			'{'{ACT_SUBDIV,  16'sd0,    16'sd0,    17'd0},     5'd1,  1'b1, EMPTY_BEAT},
			'{'{ACT_APPEND,  C_MIN,     C_MAX,     17'd0},     5'd1,  1'b0, NO_BEAT},
			'{'{ACT_EVAL,    16'sd0,    16'sd0,    17'd0},     5'd1,  1'b1, CORNER_BEAT},
			'{'{ACT_EVAL,    16'sd0,    16'sd0,    T_MAX},     5'd1,  1'b1, CORNER_BEAT},
			'{'{ACT_SUBDIV,  16'sd0,    16'sd0,    17'd0},     5'd1,  1'b0, NO_BEAT},
			'{'{ACT_APPEND,  C_MAX,     C_MIN,     17'd0},     5'd1,  1'b0, NO_BEAT},
			'{'{ACT_EVAL,    16'sd0,    16'sd0,    ONE_Q16},   5'd1,  1'b1, OPP_BEAT},
			'{'{ACT_EVAL,    16'sd0,    16'sd0,    17'd32768}, 5'd1,  1'b0, NO_BEAT},
			'{'{ACT_SUBDIV,  16'sd0,    16'sd0,    17'd0},     5'd1,  1'b0, NO_BEAT},
			'{'{ACT_RSVD_LO, C_MAX,     C_MAX,     17'd0},     5'd1,  1'b0, NO_BEAT},
			'{'{ACT_RSVD_HI, 16'shffff, 16'shffff, T_MAX},     5'd1,  1'b0, NO_BEAT},
			'{'{ACT_DROP,    16'sd0,    16'sd0,    17'd0},     5'd1,  1'b0, NO_BEAT},
			'{'{ACT_EVAL,    16'sd0,    16'sd0,    ONE_Q16},   5'd1,  1'b1, CORNER_BEAT},
			'{'{ACT_CLEAR,   16'sd0,    16'sd0,    17'd0},     5'd1,  1'b0, NO_BEAT},
			'{'{ACT_EVAL,    16'sd0,    16'sd0,    17'd100},   5'd1,  1'b1, EMPTY_BEAT},
			'{'{ACT_APPEND,  16'sd1234, -16'sd987, 17'd0},     5'd16, 1'b0, NO_BEAT},
			'{'{ACT_APPEND,  C_MAX,     C_MAX,     17'd0},     5'd1,  1'b1, FULL_BEAT},
			'{'{ACT_EVAL,    16'sd0,    16'sd0,    17'd1},     5'd1,  1'b0, NO_BEAT},
			'{'{ACT_SUBDIV,  16'sd0,    16'sd0,    17'd0},     5'd1,  1'b0, NO_BEAT},
			'{'{ACT_DROP,    16'sd0,    16'sd0,    17'd0},     5'd1,  1'b0, NO_BEAT}
		};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_table[r])
			repeat (dir_table[r].reps)
				send_item(dir_table[r].item, dir_table[r].has_beat, dir_table[r].beat);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain(SETTLE);
			write_split(split_plan[ph]);
			long_hold_req = (ph == 1);
			calm_phase = (ph == 3);
			items_sent = 0;
			while (items_sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) < 7) begin
					run_curve_sequence();
				end else begin
					it.action  = 3'($urandom);
					it.point_x = COORD_W'($urandom);
					it.point_y = COORD_W'($urandom);
					it.eval_t  = T_W'($urandom_range(0, T_MAX));
					send_item(it, 1'b0, NO_BEAT);
				end
			end
		end
		calm_phase = 1'b0;
		drain(50);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall = LONG_HOLD;
			end else begin
				stall = (calm_phase || calm_seq) ? 0 : $urandom_range(0, 10);
			end
			@(negedge clk);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t unexpected beat: x=%0d y=%0d right=%0b last=%0b err=%0d",
						$time, out_data.out_x, out_data.out_y, out_data.right_half,
						out_data.last, out_data.error);
			end else begin
				want = expected_beats.pop_front();
				if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
					out_data.right_half !== want.right_half || out_data.last !== want.last ||
					out_data.error !== want.error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t beat mismatch: exp x=%0d y=%0d right=%0b last=%0b err=%0d, %s",
							$time, want.out_x, want.out_y, want.right_half, want.last,
							want.error,
							$sformatf("got x=%0d y=%0d right=%0b last=%0b err=%0d",
								out_data.out_x, out_data.out_y, out_data.right_half,
								out_data.last, out_data.error));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

endmodule
